// File: hw/rtl/dqpf_pkg.sv
// Shared types and constants for the output-restricted deque.
`timescale 1ns / 1ps
`default_nettype none

package dqpf_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = IDX_W + 1;
  localparam int FUNC_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int DOUT_W     = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_PUSH   = 2'd1,
    FN_POP    = 2'd2,
    FN_PEEK   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_EXEC,
    CTRL_FIN
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             can_finish;
    logic [CNT_W-1:0] occ;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/dqpf_if.sv
// Request and response channel interfaces for the deque.
`timescale 1ns / 1ps
`default_nettype none

interface dqpf_req_if;
  logic                                valid;
  logic                                ready;
  dqpf_pkg::func_e                     func;
  logic [dqpf_pkg::VALUE_W-1:0]        value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface dqpf_rsp_if;
  logic                                valid;
  logic                                ready;
  dqpf_pkg::status_e                   status;
  logic [dqpf_pkg::DOUT_W-1:0]         data_out;
  logic                                now_empty;

  modport source (output valid, output status, output data_out, output now_empty,
                  input ready);
  modport sink   (input valid, input status, input data_out, input now_empty,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dqpf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dqpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire  [$clog2(DEPTH)-1:0]        waddr_i,
  input  wire  [WIDTH-1:0]                wdata_i,
  input  wire                             re_i,
  input  wire  [$clog2(DEPTH)-1:0]        raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dqpf_datapath.sv
// Deque datapath: ring pointers, entry RAM and the result register.
`timescale 1ns / 1ps
`default_nettype none

module dqpf_datapath (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  dqpf_pkg::dp_cmd_t             cmd_i,
  output dqpf_pkg::dp_stat_t                  stat_o,
  input  wire  dqpf_pkg::func_e               func_i,
  input  wire  [dqpf_pkg::VALUE_W-1:0]        value_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output dqpf_pkg::status_e                   out_status_o,
  output logic [dqpf_pkg::DOUT_W-1:0]         out_data_o,
  output logic                                out_empty_o
);

  localparam int IW = dqpf_pkg::IDX_W;
  localparam int CW = dqpf_pkg::CNT_W;
  localparam int SW = dqpf_pkg::SUM_W;
  localparam int DW = dqpf_pkg::DATA_WIDTH;

  // Latched request
  dqpf_pkg::func_e          func_q;
  logic [DW-1:0]            value_q;

  // Ring state
  logic [IW-1:0]            front_q, front_d;
  logic [CW-1:0]            occ_q, occ_d;

  // Pending result between execute and finish
  dqpf_pkg::status_e        pend_status_q, pend_status_d;
  logic                     pend_empty_q, pend_empty_d;
  logic                     pend_rd_q, pend_rd_d;

  // Result register
  logic                     out_valid_q, out_valid_d;
  dqpf_pkg::status_e        out_status_q;
  logic [dqpf_pkg::DOUT_W-1:0] out_data_q;
  logic                     out_empty_q;

  // RAM port signals
  logic                     ram_we, ram_re;
  logic [IW-1:0]            ram_waddr;
  logic [DW-1:0]            ram_rdata;

  logic                     is_insert, is_full, is_empty;
  logic [SW-1:0]            back_sum;
  logic [IW-1:0]            back_idx, front_dec, front_inc;

  assign is_insert = (func_q == dqpf_pkg::FN_APPEND) || (func_q == dqpf_pkg::FN_PUSH);
  assign is_full   = (occ_q == CW'(dqpf_pkg::DEPTH));
  assign is_empty  = (occ_q == '0);

  // Slot just past the back; occupancy is below DEPTH whenever it is used.
  assign back_sum  = SW'(front_q) + SW'(occ_q);
  assign back_idx  = (back_sum >= SW'(dqpf_pkg::DEPTH))
                   ? IW'(back_sum - SW'(dqpf_pkg::DEPTH)) : IW'(back_sum);
  assign front_dec = (front_q == '0) ? IW'(dqpf_pkg::DEPTH - 1) : IW'(front_q - 1'b1);
  assign front_inc = (front_q == IW'(dqpf_pkg::DEPTH - 1)) ? '0 : IW'(front_q + 1'b1);

  always_comb begin
    front_d       = front_q;
    occ_d         = occ_q;
    pend_status_d = pend_status_q;
    pend_empty_d  = pend_empty_q;
    pend_rd_d     = pend_rd_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = back_idx;
    if (cmd_i.exec) begin
      pend_status_d = dqpf_pkg::STAT_OK;
      pend_rd_d     = 1'b0;
      if (is_insert) begin
        if (is_full) begin
          pend_status_d = dqpf_pkg::STAT_FULL;
        end else begin
          ram_we = 1'b1;
          occ_d  = CW'(occ_q + 1'b1);
          if (func_q == dqpf_pkg::FN_PUSH) begin
            front_d   = front_dec;
            ram_waddr = front_dec;
          end
        end
      end else begin
        if (is_empty) begin
          pend_status_d = dqpf_pkg::STAT_EMPTY;
        end else begin
          ram_re    = 1'b1;
          pend_rd_d = 1'b1;
          if (func_q == dqpf_pkg::FN_POP) begin
            front_d = front_inc;
            occ_d   = CW'(occ_q - 1'b1);
          end
        end
      end
      pend_empty_d = (occ_d == '0);
    end
  end

  // Finish has priority over a taken result: the controller only finishes
  // when the register is free or being drained this cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q       <= '0;
      occ_q         <= '0;
      out_valid_q   <= 1'b0;
      pend_rd_q     <= 1'b0;
      pend_empty_q  <= 1'b1;
      pend_status_q <= dqpf_pkg::STAT_OK;
    end else begin
      front_q       <= front_d;
      occ_q         <= occ_d;
      out_valid_q   <= out_valid_d;
      pend_rd_q     <= pend_rd_d;
      pend_empty_q  <= pend_empty_d;
      pend_status_q <= pend_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= DW'(value_i);
    end
    if (cmd_i.finish) begin
      out_status_q <= pend_status_q;
      out_data_q   <= pend_rd_q ? dqpf_pkg::DOUT_W'(ram_rdata) : '0;
      out_empty_q  <= pend_empty_q;
    end
  end

  dqpf_ram #(
    .WIDTH (DW),
    .DEPTH (dqpf_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_q),
    .re_i    (ram_re),
    .raddr_i (front_q),
    .rdata_o (ram_rdata)
  );

  assign stat_o.can_finish = !out_valid_q || out_ready_i;
  assign stat_o.occ        = occ_q;
  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_data_o        = out_data_q;
  assign out_empty_o       = out_empty_q;

endmodule

`default_nettype wire

// File: hw/rtl/dqpf_ctrl.sv
// Deque controller: sequences accept, execute and finish of one request.
`timescale 1ns / 1ps
`default_nettype none

module dqpf_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  dqpf_pkg::dp_stat_t    stat_i,
  output dqpf_pkg::dp_cmd_t           cmd_o
);

  dqpf_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dqpf_pkg::CTRL_IDLE: begin
        if (in_valid_i) state_d = dqpf_pkg::CTRL_EXEC;
      end
      dqpf_pkg::CTRL_EXEC: begin
        state_d = dqpf_pkg::CTRL_FIN;
      end
      dqpf_pkg::CTRL_FIN: begin
        if (stat_i.can_finish) state_d = dqpf_pkg::CTRL_IDLE;
      end
      default: begin
        state_d = dqpf_pkg::CTRL_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      dqpf_pkg::CTRL_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      dqpf_pkg::CTRL_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      dqpf_pkg::CTRL_FIN: begin
        cmd_o.finish = stat_i.can_finish;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqpf_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/deque_push_pop_front_core.sv
// Top level of the output-restricted deque: controller plus datapath.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   func, value
//   rsp_o    out  valid/ready   status, data_out, now_empty
//
// A transaction runs from acceptance to a loaded result in three steps:
// accept, then the ring update and RAM access, then the result load
// (the RAM read is registered, so peek/pop data is ready for the load).
// A new request is accepted while an earlier result still waits in the
// output register; only the result load stalls on rsp_o.ready.
// Reset clears the pointers and occupancy; ring contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module deque_push_pop_front_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  dqpf_req_if.sink   req_i,
  dqpf_rsp_if.source rsp_o
);

  dqpf_pkg::dp_cmd_t  dp_cmd;
  dqpf_pkg::dp_stat_t dp_stat;

  // Sequence one transaction at a time.
  dqpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Hold the ring, its pointers and the result register.
  dqpf_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .func_i       (req_i.func),
    .value_i      (req_i.value),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_status_o (rsp_o.status),
    .out_data_o   (rsp_o.data_out),
    .out_empty_o  (rsp_o.now_empty)
  );

`ifndef NO_ASSERTIONS
  // Occupancy never passes the ring size.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_stat.occ <= dqpf_pkg::CNT_W'(dqpf_pkg::DEPTH))
    else $error("deque occupancy above depth");

  // One transaction in flight: no accept right after an accept.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // A result only appears after the controller finished a transaction.
  a_rsp_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(dp_cmd.finish))
    else $error("result valid without finish");

  // Finish never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.finish |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// File: bench/deque_push_pop_front_core_test.sv
// Self-checking testbench for the output-restricted deque core.
`timescale 1ns / 1ps

module deque_push_pop_front_core_test;

  // One response as the deque should return it.
  typedef struct {
    dqpf_pkg::status_e                status;
    logic [dqpf_pkg::DOUT_W-1:0]      data;
    logic                             empty;
  } deque_rsp_t;

  // One row of the directed table. A row with a count above one issues that
  // many requests, stepping the value by one each time. Rows with has_want
  // set carry a typed-in response; the rest rely on the deque tracker.
  typedef struct {
    dqpf_pkg::func_e                  func;
    logic [dqpf_pkg::VALUE_W-1:0]     value;
    int                               count;
    bit                               has_want;
    dqpf_pkg::status_e                status;
    logic [dqpf_pkg::DOUT_W-1:0]      data;
    logic                             empty;
  } dir_row_t;

  localparam int NUM_ROWS     = 12;
  localparam int RAND_ITEMS   = 800;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 12;

  logic clk_i;
  logic rst_ni;

  dqpf_req_if req_ch ();
  dqpf_rsp_if rsp_ch ();

  deque_push_pop_front_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Tracked copy of the deque: ring contents, front slot and fill count.
  logic [dqpf_pkg::DATA_WIDTH-1:0] ring_mem [dqpf_pkg::DEPTH];
  int                              ring_head;
  int                              ring_count;

  // Responses still owed by the core, oldest first.
  deque_rsp_t rsp_expected[$];

  int errors;
  int rx_gap;
  bit calm;        // when set, neither side idles
  bit hold_start;  // asks the hold-off process to start
  bit hold_on;     // receiver holds ready low while set

  dir_row_t dir_rows [NUM_ROWS];

  // Clock: 8 ns period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Idle cycles before the next transaction on either side.
  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Apply one request to the tracked deque and return the response it owes.
  // Inserts bounce off a full deque, pops and peeks off an empty one; in
  // both cases nothing moves and data reads as zero.
  function automatic deque_rsp_t track_request(dqpf_pkg::func_e f,
                                               logic [dqpf_pkg::VALUE_W-1:0] v);
    deque_rsp_t r;
    r.status = dqpf_pkg::STAT_OK;
    r.data   = '0;
    case (f) inside
      dqpf_pkg::FN_APPEND, dqpf_pkg::FN_PUSH: begin
        if (ring_count >= dqpf_pkg::DEPTH) begin
          r.status = dqpf_pkg::STAT_FULL;
        end else if (f == dqpf_pkg::FN_APPEND) begin
          ring_mem[(ring_head + ring_count) % dqpf_pkg::DEPTH] =
            v[dqpf_pkg::DATA_WIDTH-1:0];
          ring_count++;
        end else begin
          // Step the front back one slot and write there.
          ring_head = (ring_head + dqpf_pkg::DEPTH - 1) % dqpf_pkg::DEPTH;
          ring_mem[ring_head] = v[dqpf_pkg::DATA_WIDTH-1:0];
          ring_count++;
        end
      end
      default: begin
        if (ring_count == 0) begin
          r.status = dqpf_pkg::STAT_EMPTY;
        end else begin
          r.data = dqpf_pkg::DOUT_W'(ring_mem[ring_head]);
          if (f == dqpf_pkg::FN_POP) begin
            ring_head = (ring_head + 1) % dqpf_pkg::DEPTH;
            ring_count--;
          end
        end
      end
    endcase
    r.empty = (ring_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field,
                                 input logic [dqpf_pkg::DOUT_W-1:0] got,
                                 input logic [dqpf_pkg::DOUT_W-1:0] want);
    $display("%0t: response %s mismatch: got %h, want %h", $realtime, field, got, want);
    errors++;
  endtask

  // Offer one request after a random gap and hold it until it is taken.
  // The expected response is recorded at the edge the transaction happens.
  task automatic send_req(input dqpf_pkg::func_e f,
                          input logic [dqpf_pkg::VALUE_W-1:0] v);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.value <= v;
    do @(posedge clk_i); while (!req_ch.ready);
    rsp_expected.push_back(track_request(f, v));
  endtask

  // Directed table: empty deque, front/back order at the value extremes,
  // a fill to capacity with both insert kinds, then inserts against a full
  // deque. The value field on pops and peeks is junk that must be ignored.
  initial begin
    dir_rows[0]  = '{dqpf_pkg::FN_PEEK,   32'hDEAD_BEEF, 1, 1'b1,
                     dqpf_pkg::STAT_EMPTY, 32'h0,         1'b1};
    dir_rows[1]  = '{dqpf_pkg::FN_POP,    32'hFFFF_FFFF, 1, 1'b1,
                     dqpf_pkg::STAT_EMPTY, 32'h0,         1'b1};
    dir_rows[2]  = '{dqpf_pkg::FN_APPEND, 32'h0000_0000, 1, 1'b1,
                     dqpf_pkg::STAT_OK,    32'h0,         1'b0};
    dir_rows[3]  = '{dqpf_pkg::FN_PUSH,   32'hFFFF_FFFF, 1, 1'b1,
                     dqpf_pkg::STAT_OK,    32'h0,         1'b0};
    dir_rows[4]  = '{dqpf_pkg::FN_PEEK,   32'h1234_5678, 1, 1'b1,
                     dqpf_pkg::STAT_OK,    32'hFFFF_FFFF, 1'b0};
    dir_rows[5]  = '{dqpf_pkg::FN_POP,    32'h0000_0000, 1, 1'b1,
                     dqpf_pkg::STAT_OK,    32'hFFFF_FFFF, 1'b0};
    dir_rows[6]  = '{dqpf_pkg::FN_POP,    32'hA5A5_A5A5, 1, 1'b1,
                     dqpf_pkg::STAT_OK,    32'h0,         1'b1};
    dir_rows[7]  = '{dqpf_pkg::FN_APPEND, 32'h8000_0001, 8, 1'b0,
                     dqpf_pkg::STAT_OK,    32'h0,         1'b0};
    dir_rows[8]  = '{dqpf_pkg::FN_PUSH,   32'h7FFF_FFF0, 8, 1'b0,
                     dqpf_pkg::STAT_OK,    32'h0,         1'b0};
    dir_rows[9]  = '{dqpf_pkg::FN_APPEND, 32'h5555_AAAA, 1, 1'b1,
                     dqpf_pkg::STAT_FULL,  32'h0,         1'b0};
    dir_rows[10] = '{dqpf_pkg::FN_PUSH,   32'hAAAA_5555, 1, 1'b1,
                     dqpf_pkg::STAT_FULL,  32'h0,         1'b0};
    dir_rows[11] = '{dqpf_pkg::FN_PEEK,   32'h0000_0000, 1, 1'b0,
                     dqpf_pkg::STAT_OK,    32'h0,         1'b0};
  end

  // Receiver: drop ready for the drawn gap after each transaction, and for
  // the whole hold-off window.
  always @(negedge clk_i) begin
    if (hold_on || rx_gap > 0) begin
      rsp_ch.ready <= 1'b0;
      if (rx_gap > 0) rx_gap--;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here in cycles. The sender keeps
  // offering requests meanwhile, so the core backs up and drops req ready.
  initial begin
    hold_on = 1'b0;
    wait (hold_start);
    @(posedge clk_i);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on = 1'b0;
  end

  // Response checker: compare every response transaction with the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin : rsp_check
    deque_rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      rx_gap = draw_gap();
      if (rsp_expected.size() == 0) begin
        report_mismatch("unexpected", rsp_ch.data_out, '0);
      end else begin
        want = rsp_expected.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", dqpf_pkg::DOUT_W'(rsp_ch.status),
                          dqpf_pkg::DOUT_W'(want.status));
        if (rsp_ch.data_out !== want.data)
          report_mismatch("data_out", rsp_ch.data_out, want.data);
        if (rsp_ch.now_empty !== want.empty)
          report_mismatch("now_empty", dqpf_pkg::DOUT_W'(rsp_ch.now_empty),
                          dqpf_pkg::DOUT_W'(want.empty));
      end
    end
  end

  // Run limit: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Main sequence.
  initial begin
    int                           bias;
    dqpf_pkg::func_e              f;
    logic [dqpf_pkg::VALUE_W-1:0] v;

    errors       = 0;
    rx_gap       = 0;
    calm         = 1'b0;
    hold_start   = 1'b0;
    ring_head    = 0;
    ring_count   = 0;
    bias         = 50;
    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func  = dqpf_pkg::FN_APPEND;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table; typed-in responses replace the tracked ones.
    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].count; k++) begin
        send_req(dir_rows[r].func, dir_rows[r].value + dqpf_pkg::VALUE_W'(k));
        if (dir_rows[r].has_want)
          rsp_expected[rsp_expected.size() - 1] =
            '{dir_rows[r].status, dir_rows[r].data, dir_rows[r].empty};
      end
    end

    // Random part in bursts: each burst leans toward inserts or toward
    // removals, so the deque swings between full and empty many times.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 3))
          0:       bias = 90;
          1:       bias = 15;
          2:       bias = 70;
          default: bias = 40;
        endcase
      end
      // Every fourth stretch runs back to back on both sides.
      calm = ((n / 96) % 4 == 3);
      if (n == 250) hold_start = 1'b1;

      if ($urandom_range(0, 99) < bias)
        f = $urandom_range(0, 1) ? dqpf_pkg::FN_APPEND : dqpf_pkg::FN_PUSH;
      else
        f = ($urandom_range(0, 3) != 0) ? dqpf_pkg::FN_POP : dqpf_pkg::FN_PEEK;

      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = '1;
        default: v = $urandom();
      endcase
      send_req(f, v);
    end

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    calm = 1'b1;

    // Wait out the remaining responses, then a drain window for strays.
    while (rsp_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && rsp_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
